// ===== rtl/uwh_pkg.sv =====
// Package for the universal word hash accumulator.
// Holds widths, register indexes, reset values and the sequencer types.
// No dependencies.
package uwh_pkg;

	localparam int XLEN      = 64;
	localparam int DLEN      = 63;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIME      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd3;

	localparam logic [XLEN-1:0] MULT_RESET   = 64'd1;
	localparam logic [XLEN-1:0] OFFSET_RESET = 64'd0;
	localparam logic [DLEN-1:0] PRIME_RESET  = 63'd2147483647;
	localparam logic [DLEN-1:0] TABLE_RESET  = 63'd1024;

	localparam logic [CNT_W-1:0] CNT_LAST = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_OFS,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_ACC
	} state_t;

	// Sequencer to datapath control.
	typedef struct packed {
		state_t phase;
		logic   pass;
		logic   start;
		logic   acc_go;
		logic   last;
	} ctl_t;

	// Datapath to sequencer status.
	typedef struct packed {
		logic div_zero;
	} stat_t;

endpackage

// ===== rtl/uwh_stream_if.sv =====
// Stream interfaces for message words and hash results.
// Depends on uwh_pkg for the data width.
interface uwh_word_if
	import uwh_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [XLEN-1:0] word;
	logic                   last;

	modport source (output valid, output word, output last, input ready);
	modport sink   (input valid, input word, input last, output ready);
endinterface

interface uwh_hash_if
	import uwh_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [XLEN-1:0] hash_sum;

	modport source (output valid, output hash_sum, input ready);
	modport sink   (input valid, input hash_sum, output ready);
endinterface

// ===== rtl/uwh_ctrl.sv =====
// Sequencer for the hash accumulator: phase state machine and bit counter.
// Depends on uwh_pkg.
module uwh_ctrl
	import uwh_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  start_last,
	input  logic  out_busy,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  ready
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             pass_q, pass_d;
	logic             last_q;
	logic             acc_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pass_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pass_q  <= pass_d;
			if (start) begin
				last_q <= start_last;
			end
		end
	end

	// A closing word waits in the accumulate phase until the result register is free.
	assign acc_go = (state_q == ST_ACC) && (!last_q || !out_busy);

	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		cnt_d   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_OFS;
				end
			end
			ST_OFS: begin
				pass_d  = 1'b0;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				// A zero divisor leaves the value as it is and skips the pass.
				if (stat.div_zero) begin
					if (pass_q) begin
						state_d = ST_ACC;
					end else begin
						pass_d = 1'b1;
					end
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (pass_q) begin
					state_d = ST_ACC;
				end else begin
					pass_d  = 1'b1;
					state_d = ST_ABS;
				end
			end
			ST_ACC: begin
				if (acc_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ready      = (state_q == ST_IDLE);
	assign ctl.phase  = state_q;
	assign ctl.pass   = pass_q;
	assign ctl.start  = start;
	assign ctl.acc_go = acc_go;
	assign ctl.last   = last_q;

endmodule

// ===== rtl/uwh_datapath.sv =====
// Datapath of the hash accumulator built around one shared 65-bit adder.
// Runs shift-add multiply, restoring remainder and sign fixes. Depends on uwh_pkg.
module uwh_datapath
	import uwh_pkg::*;
(
	input  logic            clk,
	input  ctl_t            ctl,
	input  logic [XLEN-1:0] word,
	input  logic [XLEN-1:0] multiplier,
	input  logic [XLEN-1:0] offset,
	input  logic [DLEN-1:0] prime_modulus,
	input  logic [DLEN-1:0] table_size,
	input  logic [XLEN-1:0] running_sum,
	output stat_t           stat,
	output logic [XLEN-1:0] add_res
);

	logic [XLEN-1:0] val_q;
	logic [XLEN-1:0] a_q;
	logic [XLEN-1:0] b_q;
	logic            neg_q;

	logic [DLEN-1:0] divisor;
	logic [XLEN-1:0] shifted;
	logic [XLEN:0]   op_a, op_b, sum;
	logic            cin;
	logic            fits;

	assign divisor = ctl.pass ? table_size : prime_modulus;
	assign shifted = {b_q[XLEN-2:0], a_q[XLEN-1]};

	always_comb begin
		op_a = '0;
		op_b = '0;
		cin  = 1'b0;
		case (ctl.phase)
			ST_MUL: begin
				op_a = {1'b0, val_q};
				op_b = {1'b0, a_q};
			end
			ST_OFS: begin
				op_a = {1'b0, val_q};
				op_b = {1'b0, offset};
			end
			ST_ABS: begin
				op_b = val_q[XLEN-1] ? {1'b0, ~val_q} : {1'b0, val_q};
				cin  = val_q[XLEN-1];
			end
			ST_DIV: begin
				op_a = {1'b0, shifted};
				op_b = ~{2'b00, divisor};
				cin  = 1'b1;
			end
			ST_SIGN: begin
				op_b = neg_q ? {1'b0, ~b_q} : {1'b0, b_q};
				cin  = neg_q;
			end
			ST_ACC: begin
				op_a = {1'b0, running_sum};
				op_b = {1'b0, val_q};
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign sum  = op_a + op_b + {{XLEN{1'b0}}, cin};
	// The trial subtract cannot go below -2^64, so bit 64 is the borrow.
	assign fits = !sum[XLEN];

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			val_q <= '0;
			a_q   <= word;
			b_q   <= multiplier;
		end else begin
			case (ctl.phase)
				ST_MUL: begin
					if (b_q[0]) begin
						val_q <= sum[XLEN-1:0];
					end
					a_q <= {a_q[XLEN-2:0], 1'b0};
					b_q <= {1'b0, b_q[XLEN-1:1]};
				end
				ST_OFS: begin
					val_q <= sum[XLEN-1:0];
				end
				ST_ABS: begin
					neg_q <= val_q[XLEN-1];
					a_q   <= sum[XLEN-1:0];
					b_q   <= '0;
				end
				ST_DIV: begin
					b_q <= fits ? sum[XLEN-1:0] : shifted;
					a_q <= {a_q[XLEN-2:0], 1'b0};
				end
				ST_SIGN: begin
					val_q <= sum[XLEN-1:0];
				end
				default: begin
					val_q <= val_q;
				end
			endcase
		end
	end

	assign stat.div_zero = (divisor == '0);
	assign add_res       = sum[XLEN-1:0];

endmodule

// ===== rtl/universal_word_hash_accumulator.sv =====
// Universal word hash accumulator: ((word*multiplier + offset) rem prime) rem table_size,
// summed over a message. Each word runs the multiply steps, the offset add, two remainder
// passes (absolute value, divide steps, sign fix) and the accumulate; a zero divisor skips
// the divide steps and sign fix of its pass. A new word is taken only once the last one is
// through, as all steps share the one adder. Reset clears the running sum, the result valid
// flag and the sequencer and loads the register reset values; no clearing pass is needed.
module universal_word_hash_accumulator
	import uwh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [XLEN-1:0]      cfg_data,
	uwh_word_if.sink             msg,
	uwh_hash_if.source           hash
);

	logic [XLEN-1:0] mult_q;
	logic [XLEN-1:0] offset_q;
	logic [DLEN-1:0] prime_q;
	logic [DLEN-1:0] table_q;
	logic [XLEN-1:0] sum_q;
	logic [XLEN-1:0] out_q;
	logic            out_valid_q;

	ctl_t            ctl;
	stat_t           stat;
	logic            ready;
	logic            start;
	logic [XLEN-1:0] add_res;

	assign start = msg.valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q   <= MULT_RESET;
			offset_q <= OFFSET_RESET;
			prime_q  <= PRIME_RESET;
			table_q  <= TABLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MULTIPLIER: mult_q   <= cfg_data;
				CFG_OFFSET:     offset_q <= cfg_data;
				CFG_PRIME:      prime_q  <= cfg_data[DLEN-1:0];
				CFG_TABLE_SIZE: table_q  <= cfg_data[DLEN-1:0];
				default:        mult_q   <= mult_q;
			endcase
		end
	end

	uwh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_last (msg.last),
		.out_busy   (out_valid_q && !hash.ready),
		.stat       (stat),
		.ctl        (ctl),
		.ready      (ready)
	);

	uwh_datapath u_datapath (
		.clk           (clk),
		.ctl           (ctl),
		.word          (msg.word),
		.multiplier    (mult_q),
		.offset        (offset_q),
		.prime_modulus (prime_q),
		.table_size    (table_q),
		.running_sum   (sum_q),
		.stat          (stat),
		.add_res       (add_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.acc_go && ctl.last) begin
				out_valid_q <= 1'b1;
			end else if (hash.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.acc_go) begin
				if (ctl.last) begin
					sum_q <= '0;
				end else begin
					sum_q <= add_res;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_go && ctl.last) begin
			out_q <= add_res;
		end
	end

	assign msg.ready     = ready;
	assign hash.valid    = out_valid_q;
	assign hash.hash_sum = out_q;

	// A word transfer always starts a multi-cycle computation.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready) |=> !msg.ready)
		else $error("input ready right after a word transfer");

	// A result appears only out of the accumulate phase.
	a_result_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash.valid) |-> $past(ctl.phase == ST_ACC))
		else $error("result loaded outside the accumulate phase");

	// Emitting a result clears the running sum.
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash.valid) |-> (sum_q == '0))
		else $error("running sum not cleared with the result");

endmodule

// ===== tb/universal_word_hash_accumulator_tb.sv =====
// Testbench for universal_word_hash_accumulator: streams signed word messages, predicts
// every hash sum in its own model and checks each result transfer in order.
// Depends on uwh_pkg, the uwh_word_if and uwh_hash_if interfaces and the RTL top.
`timescale 1ns / 1ps

module universal_word_hash_accumulator_tb;
	import uwh_pkg::*;

	localparam logic [XLEN-1:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [XLEN-1:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DLEN-1:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 260;
	localparam int STALL_CYCLES  = 3000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [XLEN-1:0]      cfg_data;

	uwh_word_if msg_if();
	uwh_hash_if hash_if();

	universal_word_hash_accumulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.msg      (msg_if),
		.hash     (hash_if)
	);

	// Predictor state: register copies and the sum of the message in progress.
	logic [XLEN-1:0] mult_q;
	logic [XLEN-1:0] offset_q;
	logic [DLEN-1:0] prime_q;
	logic [DLEN-1:0] tsize_q;
	logic [XLEN-1:0] msg_sum;
	logic [XLEN-1:0] expected_sums[$];

	int send_idle_pct = 8;
	int recv_idle_pct = 67;
	logic rx_hold = 1'b0;
	event out_stall_ev;
	int unsigned quiet_cycles = 0;

	int n_errors = 0;
	int n_words  = 0;
	int n_sums   = 0;
	int n_writes = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Truncated remainder: sign follows the dividend, a zero divisor passes it through.
	function automatic logic [XLEN-1:0] trunc_rem(logic [XLEN-1:0] num, logic [DLEN-1:0] den);
		logic [XLEN-1:0] mag;
		logic [XLEN-1:0] r;
		if (den == '0)
			return num;
		mag = num[XLEN-1] ? -num : num;
		r = mag % {1'b0, den};
		return num[XLEN-1] ? -r : r;
	endfunction

	function automatic logic [XLEN-1:0] word_term(logic [XLEN-1:0] w);
		logic [XLEN-1:0] x;
		x = w * mult_q + offset_q;
		return trunc_rem(trunc_rem(x, prime_q), tsize_q);
	endfunction

	function automatic logic [XLEN-1:0] pick_value64();
		case ($urandom_range(7))
			0: return MIN64;
			1: return MAX64;
			2: return '0;
			3: return 64'd1;
			4: return '1;
			5: return -64'($urandom_range(1000, 1));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Bit 63 is random so the masking of the 63-bit divisor registers is exercised.
	function automatic logic [XLEN-1:0] pick_divisor();
		logic [DLEN-1:0] v;
		case ($urandom_range(8))
			0: v = '0;
			1: v = 63'd1;
			2: v = 63'd2;
			3: v = 63'd2147483647;
			4: v = MAX63;
			5: v = 63'($urandom_range(65535, 3));
			6: v = 63'({$urandom, $urandom}) >> $urandom_range(62, 1);
			default: v = 63'({$urandom, $urandom});
		endcase
		return {1'($urandom_range(1)), v};
	endfunction

	function automatic logic [XLEN-1:0] pick_word();
		case ($urandom_range(15))
			0: return MIN64;
			1: return MAX64;
			2: return '0;
			3: return '1;
			4: return 64'($urandom_range(1000));
			5: return -64'($urandom_range(1000, 1));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
		n_errors++;
		if (n_errors <= 50)
			$display("[%0t] %s: got %h, want %h", $time, what, got, want);
	endtask

	// Leaves cfg_we high; load_config lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [XLEN-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		n_writes++;
		case (idx)
			CFG_MULTIPLIER: mult_q = data;
			CFG_OFFSET:     offset_q = data;
			CFG_PRIME:      prime_q = data[DLEN-1:0];
			CFG_TABLE_SIZE: tsize_q = data[DLEN-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [XLEN-1:0] mult, input logic [XLEN-1:0] ofs,
			input logic [XLEN-1:0] prime, input logic [XLEN-1:0] tsize);
		write_reg(CFG_MULTIPLIER, mult);
		write_reg(CFG_OFFSET, ofs);
		write_reg(CFG_PRIME, prime);
		write_reg(CFG_TABLE_SIZE, tsize);
		cfg_we <= 1'b0;
	endtask

	// Offers one word, waits for its transfer and updates the predicted sum.
	// Ready only moves at rising edges, so its value at the falling edge is
	// the one that the following rising edge sees.
	task automatic send_word(input logic [XLEN-1:0] w, input logic is_last);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.word <= w;
		msg_if.last <= is_last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = msg_if.ready;
			@(posedge clk);
		end
		n_words++;
		msg_sum += word_term(w);
		if (is_last) begin
			expected_sums.push_back(msg_sum);
			msg_sum = '0;
		end
	endtask

	// A word that closes no message can still be in the datapath when the queue
	// empties, so the block must also have seen no transfer for a full latency.
	task automatic wait_quiet();
		msg_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_sums.size() != 0 || quiet_cycles < SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Sampled at the falling edge, where the handshake of the next rising edge is settled.
	always @(negedge clk) begin
		if (msg_if.valid && msg_if.ready)
			quiet_cycles <= 0;
		else if (quiet_cycles < 100000)
			quiet_cycles <= quiet_cycles + 1;
	end

	always begin
		@(out_stall_ev);
		rx_hold <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Result side: random ready and an in-order check of every transfer.
	initial begin
		logic [XLEN-1:0] want;
		logic [XLEN-1:0] got;
		logic            seen;
		hash_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			seen = hash_if.valid && hash_if.ready;
			got  = hash_if.hash_sum;
			@(posedge clk);
			if (seen) begin
				if (expected_sums.size() == 0) begin
					report_mismatch("hash_sum with no message pending", got, 'x);
				end else begin
					want = expected_sums.pop_front();
					n_sums++;
					if (got !== want)
						report_mismatch("hash_sum", got, want);
				end
			end
			hash_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic test_reset_config();
		send_word('0, 1'b1);
		send_word(MAX64, 1'b1);
		send_word(MIN64, 1'b1);
		send_word('1, 1'b1);
		send_word(64'd12345, 1'b0);
		send_word(-64'd9876543210, 1'b0);
		send_word(MAX64, 1'b1);
		wait_quiet();
	endtask

	task automatic test_offset_variant();
		load_config(64'h9E37_79B9_7F4A_7C15, 64'h0123_4567_89AB_CDEF,
			64'd2305843009213693951, 64'd65536);
		send_word(64'd5, 1'b0);
		send_word(-64'd5, 1'b0);
		send_word(MIN64, 1'b1);
		wait_quiet();
		load_config(64'h9E37_79B9_7F4A_7C15, -64'd1000003, 64'd1000003, 64'd977);
		send_word(64'd77, 1'b0);
		send_word(-64'd77, 1'b1);
		wait_quiet();
	endtask

	task automatic test_zero_divisors();
		load_config(64'd3, 64'd7, '0, '0);
		send_word(MAX64, 1'b1);
		send_word(-64'd2, 1'b1);
		wait_quiet();
		load_config(-64'd3, '0, '0, 64'd1000);
		send_word(64'd123456789, 1'b1);
		send_word(-64'd123456789, 1'b1);
		wait_quiet();
		load_config(64'd1, -64'd100, 64'd97, '0);
		send_word(64'd50, 1'b1);
		send_word(MIN64 + 64'd1, 1'b1);
		wait_quiet();
	endtask

	task automatic test_register_extremes();
		load_config(MIN64, MAX64, {1'b1, MAX63}, {1'b1, 63'd1});
		send_word(MAX64, 1'b1);
		wait_quiet();
		load_config(MAX64, MIN64, '1, {1'b0, MAX63});
		send_word(MIN64, 1'b0);
		send_word(MAX64, 1'b1);
		wait_quiet();
		load_config('0, MIN64, 64'd1, {1'b0, MAX63});
		send_word('1, 1'b1);
		wait_quiet();
	endtask

	// The result side holds off while one-word messages keep coming, so the
	// block fills up and has to stall its input.
	task automatic test_output_stall();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		load_config(64'h0000_0001_0000_01B3, 64'd11, 64'd4294967291, 64'd4096);
		-> out_stall_ev;
		for (int k = 0; k < 6; k++)
			send_word(pick_word(), 1'b1);
		wait_quiet();
		send_idle_pct = saved_idle;
	endtask

	task automatic test_random_traffic();
		int words;
		int len;
		for (int blk = 0; blk < 13; blk++) begin
			wait_quiet();
			case (blk)
				0: begin send_idle_pct = 8; recv_idle_pct = 67; end
				4: begin send_idle_pct = 67; recv_idle_pct = 8; end
				8: begin send_idle_pct = 0; recv_idle_pct = 0; end
				default: ;
			endcase
			case (blk)
				3: load_config(MAX64, MIN64, {1'b1, MAX63}, {1'b1, MAX63});
				6: load_config(pick_value64(), pick_value64(), '0, pick_divisor());
				10: load_config(MIN64, MAX64, 64'd2147483647, 64'd2);
				11: load_config(pick_value64(), pick_value64(), pick_divisor(), '0);
				default: load_config(pick_value64(), pick_value64(), pick_divisor(),
					pick_divisor());
			endcase
			words = 0;
			while (words < 150) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
				for (int k = 1; k <= len; k++)
					send_word(pick_word(), k == len);
				words += len;
			end
		end
		wait_quiet();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MULTIPLIER;
		cfg_data <= '0;
		msg_if.valid <= 1'b0;
		msg_if.word <= '0;
		msg_if.last <= 1'b0;
		mult_q = MULT_RESET;
		offset_q = OFFSET_RESET;
		prime_q = PRIME_RESET;
		tsize_q = TABLE_RESET;
		msg_sum = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_offset_variant();
		test_zero_divisors();
		test_register_extremes();
		test_output_stall();
		test_random_traffic();

		$display("Run covered %0d words, %0d checked sums and %0d register writes,",
			n_words, n_sums, n_writes);
		$display("with zero divisors, register extremes and a %0d-cycle output stall.",
			STALL_CYCLES);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out with %0d sums still pending.", expected_sums.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/uwh_pkg.sv
rtl/uwh_stream_if.sv
rtl/uwh_ctrl.sv
rtl/uwh_datapath.sv
rtl/universal_word_hash_accumulator.sv
tb/universal_word_hash_accumulator_tb.sv
